FILE: src/sete_pkg.sv
// Package for the sprite entry tile expander: position constants, field
// widths and the decoded-entry record passed from the decoder to the sequencer.
// No dependencies.
`default_nettype none

package sete_pkg;

	localparam int TILE_W   = 14;
	localparam int POS_W    = 10;
	localparam int XCALC_W  = 11;
	localparam int COLOUR_W = 5;
	localparam int CNT_W    = 3;

	// Horizontal arithmetic runs one bit wider so that the cull test sees the
	// true value before it is folded into the ten-bit field.
	localparam logic signed [XCALC_W-1:0] X_WRAP   = 11'sd320;
	localparam logic signed [XCALC_W-1:0] POS_SPAN = 11'sd512;
	localparam logic signed [XCALC_W-1:0] X_MIRROR = 11'sd304;
	localparam logic signed [XCALC_W-1:0] X_LIMIT  = 11'sd320;
	localparam logic signed [XCALC_W-1:0] X_MIN    = -11'sd15;

	localparam logic [POS_W-1:0] Y_MIRROR  = 10'd240;
	localparam logic [POS_W-1:0] Y_BIAS    = 10'd8;
	localparam logic [POS_W-1:0] TILE_STEP = 10'd16;

	typedef struct packed {
		logic                    drop;
		logic signed [POS_W-1:0] sx;
		logic [POS_W-1:0]        y_first;
		logic [TILE_W-1:0]       code_first;
		logic                    code_down;
		logic [CNT_W-1:0]        count;
		logic                    mx;
		logic                    my;
		logic [COLOUR_W-1:0]     colour;
	} sete_dec_t;

endpackage

`default_nettype wire

FILE: src/sete_if.sv
// Channel interfaces of the sprite entry tile expander: the attribute entry
// channel and the tile command channel, each with valid/ready handshake.
// Depends on sete_pkg for field widths.
`default_nettype none

interface sete_in_if;
	import sete_pkg::*;
	logic        valid;
	logic        ready;
	logic [15:0] y_attr_word;
	logic [15:0] tile_word;
	logic [15:0] x_attr_word;
	logic        odd_frame;

	modport source(output valid, y_attr_word, tile_word, x_attr_word, odd_frame,
		input ready);
	modport sink(input valid, y_attr_word, tile_word, x_attr_word, odd_frame,
		output ready);
endinterface

interface sete_out_if;
	import sete_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [TILE_W-1:0]       tile_number;
	logic signed [POS_W-1:0] screen_x;
	logic signed [POS_W-1:0] screen_y;
	logic                    mirror_x;
	logic                    mirror_y;
	logic [COLOUR_W-1:0]     colour_bank;
	logic                    last_tile;

	modport source(output valid, tile_number, screen_x, screen_y, mirror_x, mirror_y,
		colour_bank, last_tile, input ready);
	modport sink(input valid, tile_number, screen_x, screen_y, mirror_x, mirror_y,
		colour_bank, last_tile, output ready);
endinterface

`default_nettype wire

FILE: src/sete_decode.sv
// Attribute decoder: unpacks one sprite entry into the start values of the
// tile column and decides whether the sprite is dropped. Uses sete_pkg.
`default_nettype none

module sete_decode
	import sete_pkg::*;
(
	input  wire logic [15:0] y_attr_word,
	input  wire logic [15:0] tile_word,
	input  wire logic [15:0] x_attr_word,
	input  wire logic        odd_frame,
	input  wire logic        flip,
	output sete_dec_t        dec
);

	logic signed [XCALC_W-1:0] x_raw, x_wrap, x_mir, x_fin;
	logic [POS_W-1:0]          y_wrap, y_fin, col_span;
	logic [CNT_W-1:0]          multi;
	logic [TILE_W-1:0]         base, multi_ext;
	logic                      fx, fy, cull;

	always_comb begin
		fx = y_attr_word[13];
		fy = y_attr_word[14];
		multi = CNT_W'((4'd1 << y_attr_word[10:9]) - 4'd1);

		x_raw  = $signed({2'b00, x_attr_word[8:0]});
		x_wrap = (x_raw >= X_WRAP) ? x_raw - POS_SPAN : x_raw;
		x_mir  = X_MIRROR - x_wrap;
		x_fin  = flip ? x_wrap : x_mir;
		cull   = (x_fin >= X_LIMIT) || (x_fin < X_MIN);

		// Folding positions of 256 and above down by 512 is a sign extension
		// of the nine-bit field in ten-bit arithmetic.
		y_wrap   = {y_attr_word[8], y_attr_word[8:0]};
		y_fin    = flip ? y_wrap : Y_MIRROR - y_wrap;
		col_span = {{(POS_W-CNT_W-4){1'b0}}, multi, 4'b0000};

		base      = tile_word[TILE_W-1:0];
		multi_ext = {{(TILE_W-CNT_W){1'b0}}, multi};

		dec.drop       = (y_attr_word[12] && odd_frame) || cull;
		dec.sx         = x_fin[POS_W-1:0];
		dec.y_first    = flip ? y_fin - Y_BIAS + col_span : y_fin - Y_BIAS - col_span;
		dec.code_first = fy ? (base | multi_ext) : (base & ~multi_ext);
		dec.code_down  = fy;
		dec.count      = multi;
		dec.mx         = fx ^ flip;
		dec.my         = fy ^ flip;
		dec.colour     = x_attr_word[13:9];
	end

endmodule

`default_nettype wire

FILE: src/sprite_entry_tile_expander.sv
// Sprite entry tile expander: takes one sprite attribute entry and emits its
// column of 16x16 tile draw commands. Uses sete_pkg, sete_if and sete_decode.
//
// Channels: "entry" carries one three-word attribute entry plus the frame
// parity; "tile" carries tile draw commands, the final one of a sprite marked
// by last_tile. Both use valid/ready; a transfer happens on a clock edge with
// both high. cfg_we/cfg_wdata write the screen flip bit; write it only while
// the block is idle.
// Timing: an accepted entry is decoded in the transfer cycle. A column of N
// tiles (N = 1, 2, 4 or 8) then leaves at one command per cycle while the
// receiver is ready; the transfer loads the sequencer state and the first
// command then passes through the output register. A single stepping unit
// advances y and tile code once per command. A dropped entry (flicker on an
// odd frame, or off-screen) gives nothing and leaves the block idle.
// entry.ready is low while a column is emitted. A stalled receiver holds the
// command in the output register and pauses the stepping unit; nothing is
// lost. Reset clears the sequencer, the output valid and the screen flip bit.
`default_nettype none

module sprite_entry_tile_expander
	import sete_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	sete_in_if.sink    entry,
	sete_out_if.source tile
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                  state_q;
	logic                    flip_q;
	logic                    out_valid_q;
	logic [TILE_W-1:0]       out_tile_q;
	logic signed [POS_W-1:0] out_x_q;
	logic [POS_W-1:0]        out_y_q;
	logic                    out_mx_q, out_my_q, out_last_q;
	logic [COLOUR_W-1:0]     out_colour_q;

	logic [POS_W-1:0]        y_q;
	logic [TILE_W-1:0]       code_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [POS_W-1:0] sx_q;
	logic                    down_q, step_up_q, mx_q, my_q;
	logic [COLOUR_W-1:0]     colour_q;

	sete_dec_t dec;
	logic      accept, emit;

	sete_decode u_decode (
		.y_attr_word (entry.y_attr_word),
		.tile_word   (entry.tile_word),
		.x_attr_word (entry.x_attr_word),
		.odd_frame   (entry.odd_frame),
		.flip        (flip_q),
		.dec         (dec)
	);

	assign entry.ready = (state_q == ST_IDLE);
	assign accept      = entry.valid && entry.ready;
	assign emit        = (state_q == ST_RUN) && (!out_valid_q || tile.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (cfg_we) begin
			flip_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			out_tile_q   <= '0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_mx_q     <= 1'b0;
			out_my_q     <= 1'b0;
			out_colour_q <= '0;
			out_last_q   <= 1'b0;
			y_q          <= '0;
			code_q       <= '0;
			cnt_q        <= '0;
			sx_q         <= '0;
			down_q       <= 1'b0;
			step_up_q    <= 1'b0;
			mx_q         <= 1'b0;
			my_q         <= 1'b0;
			colour_q     <= '0;
		end else begin
			if (tile.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !dec.drop) begin
						state_q   <= ST_RUN;
						y_q       <= dec.y_first;
						code_q    <= dec.code_first;
						cnt_q     <= dec.count;
						sx_q      <= dec.sx;
						down_q    <= dec.code_down;
						step_up_q <= flip_q;
						mx_q      <= dec.mx;
						my_q      <= dec.my;
						colour_q  <= dec.colour;
					end
				end
				ST_RUN: begin
					if (emit) begin
						out_valid_q  <= 1'b1;
						out_tile_q   <= code_q;
						out_x_q      <= sx_q;
						out_y_q      <= y_q;
						out_mx_q     <= mx_q;
						out_my_q     <= my_q;
						out_colour_q <= colour_q;
						out_last_q   <= (cnt_q == '0);
						// The column walks from the highest tile index to index 0.
						if (cnt_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q  <= cnt_q - 1'b1;
							y_q    <= step_up_q ? y_q - TILE_STEP : y_q + TILE_STEP;
							code_q <= down_q ? code_q - 1'b1 : code_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign tile.valid       = out_valid_q;
	assign tile.tile_number = out_tile_q;
	assign tile.screen_x    = out_x_q;
	assign tile.screen_y    = $signed(out_y_q);
	assign tile.mirror_x    = out_mx_q;
	assign tile.mirror_y    = out_my_q;
	assign tile.colour_bank = out_colour_q;
	assign tile.last_tile   = out_last_q;

	a_start_column: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !dec.drop) |=> (state_q == ST_RUN))
		else $error("accepted visible sprite did not start a column");

	a_drop_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && dec.drop) |=> entry.ready)
		else $error("dropped sprite left the block busy");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cnt_q != '0) |=> (cnt_q == $past(cnt_q) - 1'b1) && (state_q == ST_RUN))
		else $error("tile counter did not step by one");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cnt_q == '0) |=> (entry.ready && out_last_q))
		else $error("final tile did not end the column");

	a_x_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		tile.valid |-> (tile.screen_x >= -10'sd15) && (tile.screen_x <= 10'sd319))
		else $error("tile command outside the visible x range");

endmodule

`default_nettype wire
